/* hdl/wbrp_pkg.sv */
package wbrp_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int SEQ_BYTES = 8;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PUT_TAG = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DELETE_TAG = 8'd1;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TAG = 3'd1;
   localparam logic [2:0] PH_KLEN = 3'd2;
   localparam logic [2:0] PH_KDATA = 3'd3;
   localparam logic [2:0] PH_VLEN = 3'd4;
   localparam logic [2:0] PH_VDATA = 3'd5;
   localparam logic [2:0] PH_IGNORE = 3'd6;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SMALL = 3'd1;
   localparam logic [2:0] ST_BAD_PUT = 3'd2;
   localparam logic [2:0] ST_BAD_DEL = 3'd3;
   localparam logic [2:0] ST_BAD_TAG = 3'd4;
   localparam logic [2:0] ST_COUNT = 3'd5;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [7:0]  byte_echo;
      logic        record_end;
      logic        record_is_put;
      logic        batch_done;
      logic [2:0]  final_status;
      logic [63:0] seq_number;
      logic [31:0] records_found;
   } rsp_item_type;

endpackage

/* hdl/wbrp_if.sv */
interface wbrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_role;
   logic [7:0]  byte_echo;
   logic        record_end;
   logic        record_is_put;
   logic        batch_done;
   logic [2:0]  final_status;
   logic [63:0] seq_number;
   logic [31:0] records_found;

   modport source (output valid, output byte_role, output byte_echo, output record_end,
                   output record_is_put, output batch_done, output final_status,
                   output seq_number, output records_found, input ready);
   modport sink (input valid, input byte_role, input byte_echo, input record_end,
                 input record_is_put, input batch_done, input final_status,
                 input seq_number, input records_found, output ready);
endinterface

interface wbrp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

/* hdl/write_batch_record_parser.sv */
// Write batch parser. Bytes of a serialised batch arrive as beats on req_bus,
// one byte and a last-byte flag per beat. Each accepted beat yields exactly one
// beat on rsp_bus giving the role of the byte, the byte itself, a record-end
// flag, the record kind, and on the last byte the batch status together with
// the sequence number and record count gathered so far.
// The put and delete tag values are written through csr_bus, which is always
// ready; index 0 is the put tag and index 1 the delete tag.
// A parser classifies each byte in the cycle it is accepted and pushes the
// result into a small queue of QUEUE_DEPTH entries; an output register drains
// the queue towards rsp_bus. One beat is accepted per cycle while the queue is
// not full. When the receiver keeps up, a result passes from its queue slot to
// the output register, and from there it is shown on rsp_bus.
// When the receiver stalls, the output register holds its beat and
// the queue fills; req_bus ready falls only once the queue is full.
// A synchronous reset empties the queue and the output register, returns the
// parser to the header and restores the tag values to 1 and 0. After each last
// byte the parser returns to the header on its own for the next batch.
module write_batch_record_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   wbrp_req_if.sink   req_bus,
   wbrp_rsp_if.source rsp_bus,
   wbrp_csr_if.sink   csr_bus
);
   import wbrp_pkg::*;

   logic         push_valid;
   logic         push_ready;
   rsp_item_type push_item;
   logic         pop_valid;
   logic         pop_ready;
   rsp_item_type pop_item;

   wbrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   wbrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   wbrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_bus)
   );

endmodule

/* hdl/wbrp_front.sv */
module wbrp_front (
   input  logic                  clock,
   input  logic                  reset,
   wbrp_req_if.sink              req,
   wbrp_csr_if.sink              csr,
   input  logic                  push_ready,
   output logic                  push_valid,
   output wbrp_pkg::rsp_item_type push_item
);
   import wbrp_pkg::*;

   logic [7:0]  put_tag_ff, put_tag_in;
   logic [7:0]  delete_tag_ff, delete_tag_in;
   logic [3:0]  header_index_ff, header_index_in;
   logic [63:0] sequence_ff, sequence_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] found_ff, found_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] accum_ff, accum_in;
   logic [2:0]  vbytes_ff, vbytes_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        is_put_ff, is_put_in;
   logic [2:0]  error_ff, error_in;

   logic        accept;
   logic [7:0]  b;
   logic [4:0]  vi_shift;
   logic [31:0] vi_len;
   logic [31:0] vi_accum_next;
   logic        vi_fail;
   logic [2:0]  role;
   logic        rec_end;
   logic [2:0]  status;

   assign csr.ready = 1'b1;
   assign req.ready = push_ready;
   assign accept = req.valid && push_ready;
   assign push_valid = req.valid;
   assign b = req.data_byte;

   assign vi_shift = {2'b00, vbytes_ff} * 5'd7;
   assign vi_fail = b[7] && (vbytes_ff >= 3'd4);
   assign vi_accum_next = accum_ff | ({25'd0, b[6:0]} << vi_shift);
   assign vi_len = accum_ff | ({24'd0, b} << vi_shift);

   always_comb begin
      put_tag_in = put_tag_ff;
      delete_tag_in = delete_tag_ff;
      if (csr.valid) begin
         case (csr.reg_index)
            REG_PUT_TAG: put_tag_in = csr.write_data;
            REG_DELETE_TAG: delete_tag_in = csr.write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      header_index_in = header_index_ff;
      sequence_in = sequence_ff;
      expected_in = expected_ff;
      found_in = found_ff;
      phase_in = phase_ff;
      accum_in = accum_ff;
      vbytes_in = vbytes_ff;
      remaining_in = remaining_ff;
      is_put_in = is_put_ff;
      error_in = error_ff;
      role = phase_ff;
      rec_end = 1'b0;
      status = ST_OK;

      case (phase_ff)
         PH_HEADER: begin
            if (header_index_ff < 4'(SEQ_BYTES)) begin
               sequence_in[{header_index_ff[2:0], 3'b000} +: 8] = b;
            end else begin
               expected_in[{header_index_ff[1:0], 3'b000} +: 8] = b;
            end
            header_index_in = header_index_ff + 4'd1;
            if (header_index_in >= 4'(HEADER_BYTES)) begin
               phase_in = PH_TAG;
            end
         end
         PH_TAG: begin
            found_in = found_ff + 32'd1;
            if (b == put_tag_ff) begin
               is_put_in = 1'b1;
               phase_in = PH_KLEN;
            end else if (b == delete_tag_ff) begin
               is_put_in = 1'b0;
               phase_in = PH_KLEN;
            end else begin
               is_put_in = 1'b0;
               error_in = ST_BAD_TAG;
               phase_in = PH_IGNORE;
            end
         end
         PH_KLEN, PH_VLEN: begin
            if (vi_fail) begin
               error_in = is_put_ff ? ST_BAD_PUT : ST_BAD_DEL;
               phase_in = PH_IGNORE;
            end else if (b[7]) begin
               accum_in = vi_accum_next;
               vbytes_in = vbytes_ff + 3'd1;
            end else begin
               accum_in = 32'd0;
               vbytes_in = 3'd0;
               if (vi_len != 32'd0) begin
                  remaining_in = vi_len;
                  phase_in = (phase_ff == PH_KLEN) ? PH_KDATA : PH_VDATA;
               end else if (phase_ff == PH_KLEN && is_put_ff) begin
                  phase_in = PH_VLEN;
               end else begin
                  rec_end = 1'b1;
                  phase_in = PH_TAG;
               end
            end
         end
         PH_KDATA, PH_VDATA: begin
            remaining_in = remaining_ff - 32'd1;
            if (remaining_in == 32'd0) begin
               if (phase_ff == PH_KDATA && is_put_ff) begin
                  phase_in = PH_VLEN;
               end else begin
                  rec_end = 1'b1;
                  phase_in = PH_TAG;
               end
            end
         end
         default: begin
            role = PH_IGNORE;
            phase_in = PH_IGNORE;
         end
      endcase

      if (req.last_byte) begin
         if (error_in != ST_OK) begin
            status = error_in;
         end else if (phase_in == PH_HEADER) begin
            status = ST_SMALL;
         end else if (phase_in != PH_TAG) begin
            status = is_put_in ? ST_BAD_PUT : ST_BAD_DEL;
         end else if (found_in != expected_in) begin
            status = ST_COUNT;
         end else begin
            status = ST_OK;
         end
      end

      push_item.byte_role = role;
      push_item.byte_echo = b;
      push_item.record_end = rec_end;
      push_item.record_is_put = (role inside {[PH_TAG:PH_VDATA]}) ? is_put_in : 1'b0;
      push_item.batch_done = req.last_byte;
      push_item.final_status = status;
      push_item.seq_number = sequence_in;
      push_item.records_found = found_in;

      if (req.last_byte) begin
         header_index_in = 4'd0;
         sequence_in = 64'd0;
         expected_in = 32'd0;
         found_in = 32'd0;
         phase_in = PH_HEADER;
         accum_in = 32'd0;
         vbytes_in = 3'd0;
         remaining_in = 32'd0;
         is_put_in = 1'b0;
         error_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         put_tag_ff <= 8'd1;
         delete_tag_ff <= 8'd0;
      end else begin
         put_tag_ff <= put_tag_in;
         delete_tag_ff <= delete_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= 4'd0;
         sequence_ff <= 64'd0;
         expected_ff <= 32'd0;
         found_ff <= 32'd0;
         phase_ff <= PH_HEADER;
         accum_ff <= 32'd0;
         vbytes_ff <= 3'd0;
         remaining_ff <= 32'd0;
         is_put_ff <= 1'b0;
         error_ff <= ST_OK;
      end else if (accept) begin
         header_index_ff <= header_index_in;
         sequence_ff <= sequence_in;
         expected_ff <= expected_in;
         found_ff <= found_in;
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         vbytes_ff <= vbytes_in;
         remaining_ff <= remaining_in;
         is_put_ff <= is_put_in;
         error_ff <= error_in;
      end
   end

endmodule

/* hdl/wbrp_queue.sv */
module wbrp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  wbrp_pkg::rsp_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output wbrp_pkg::rsp_item_type pop_item
);
   import wbrp_pkg::*;

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   rsp_item_type           slots_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item = slots_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/wbrp_back.sv */
module wbrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  wbrp_pkg::rsp_item_type pop_item,
   wbrp_rsp_if.source            rsp
);
   import wbrp_pkg::*;

   rsp_item_type out_ff;
   logic         out_valid_ff, out_valid_in;

   assign pop_ready = !out_valid_ff || rsp.ready;
   assign out_valid_in = pop_valid || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         out_ff <= pop_item;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.byte_role = out_ff.byte_role;
   assign rsp.byte_echo = out_ff.byte_echo;
   assign rsp.record_end = out_ff.record_end;
   assign rsp.record_is_put = out_ff.record_is_put;
   assign rsp.batch_done = out_ff.batch_done;
   assign rsp.final_status = out_ff.final_status;
   assign rsp.seq_number = out_ff.seq_number;
   assign rsp.records_found = out_ff.records_found;

endmodule

/* hdl/wbrp_checker.sv */
module wbrp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] byte_role,
   input logic       record_end,
   input logic       record_is_put,
   input logic       batch_done,
   input logic [2:0] final_status
);
   import wbrp_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A stalled response beat was withdrawn.");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("A response beat appeared straight after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !batch_done |-> final_status == ST_OK)
      else $error("A status was reported before the last byte.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (byte_role == PH_HEADER || byte_role == PH_IGNORE)
      |-> !record_end && !record_is_put)
      else $error("A header or ignored byte carried record flags.");

endmodule

bind write_batch_record_parser wbrp_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .byte_role     (rsp_bus.byte_role),
   .record_end    (rsp_bus.record_end),
   .record_is_put (rsp_bus.record_is_put),
   .batch_done    (rsp_bus.batch_done),
   .final_status  (rsp_bus.final_status)
);
